### sv/fpbcs_pkg.sv
package fpbcs_pkg;

    localparam int MAX_CELLS   = 8;
    localparam int INTERVAL_W  = 16;
    localparam int GAIN_W      = 7;
    localparam int PERIOD_W    = 13;
    localparam int CFG_DATA_W  = 7;

    localparam int NOM_MFM     = 2000;
    localparam int NOM_FM      = 4000;
    localparam int MIN_PCT     = 75;
    localparam int MAX_PCT     = 125;
    localparam int GAIN_RESET  = 5;

    localparam logic [PERIOD_W-1:0] MFM_NOM = PERIOD_W'(NOM_MFM);
    localparam logic [PERIOD_W-1:0] FM_NOM  = PERIOD_W'(NOM_FM);
    localparam logic [PERIOD_W-1:0] MFM_LO  = PERIOD_W'(NOM_MFM * MIN_PCT / 100);
    localparam logic [PERIOD_W-1:0] MFM_HI  = PERIOD_W'(NOM_MFM * MAX_PCT / 100);
    localparam logic [PERIOD_W-1:0] FM_LO   = PERIOD_W'(NOM_FM * MIN_PCT / 100);
    localparam logic [PERIOD_W-1:0] FM_HI   = PERIOD_W'(NOM_FM * MAX_PCT / 100);
    localparam int PERIOD_MAX = NOM_FM * MAX_PCT / 100;

    // cell index, running count*period, rounding threshold (2k+1)*period
    localparam int K_W    = $clog2(MAX_CELLS + 1);
    localparam int ACC_W  = $clog2(MAX_CELLS * PERIOD_MAX + 1);
    localparam int THR_W  = $clog2((2 * MAX_CELLS + 1) * PERIOD_MAX + 1);
    localparam int CMP_W  = (THR_W > INTERVAL_W + 1) ? THR_W : INTERVAL_W + 1;
    localparam int ERR_W  = (ACC_W > INTERVAL_W) ? ACC_W : INTERVAL_W;
    localparam int PROD_W = ERR_W + GAIN_W;

    // |err*gain| saturates at 2^SAT_W: the quotient then already exceeds
    // the whole period window, so the clamp gives the same period.
    localparam int SAT_W      = 19;
    localparam int DIV_SHIFT  = SAT_W + 7;
    localparam int RECIP      = ((2 ** DIV_SHIFT) + 99) / 100;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int RPROD_W    = SAT_W + RECIP_W;
    localparam int Q_W        = RPROD_W - DIV_SHIFT;
    localparam int NEXT_W     = PERIOD_W + 2;

    localparam logic [0:0] CFG_FM_MODE = 1'b0;
    localparam logic [0:0] CFG_GAIN    = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EMIT = 5'b00010,
        S_MUL1 = 5'b00100,
        S_MUL2 = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
        logic mul1;
        logic mul2;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_sts;

endpackage

### sv/fpbcs_dp.sv
module fpbcs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [fpbcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [fpbcs_pkg::INTERVAL_W-1:0]    i_interval_ns,
    input  logic                                i_stall,
    input  fpbcs_pkg::t_dp_cmd                  i_cmd,
    output fpbcs_pkg::t_dp_sts                  o_sts,
    output logic                                o_valid,
    output logic                                o_cell_bit,
    output logic                                o_last_cell
);

    logic                               r_fm_mode;
    logic [fpbcs_pkg::GAIN_W-1:0]       r_gain;
    logic [fpbcs_pkg::PERIOD_W-1:0]     r_period, n_period;
    logic [fpbcs_pkg::INTERVAL_W-1:0]   r_interval;
    logic [fpbcs_pkg::K_W-1:0]          r_k;
    logic [fpbcs_pkg::ACC_W-1:0]        r_acc;
    logic [fpbcs_pkg::CMP_W-1:0]        r_thr;
    logic                               r_first;
    logic                               r_neg;
    logic [fpbcs_pkg::PROD_W-1:0]       r_prod;
    logic [fpbcs_pkg::RPROD_W-1:0]      r_rprod;
    logic                               r_out_valid;
    logic                               r_out_bit;
    logic                               r_out_last;

    logic [fpbcs_pkg::PERIOD_W-1:0]     lo, hi;
    logic                               last;
    logic [fpbcs_pkg::ERR_W-1:0]        err_i, err_a, err_mag;
    logic                               err_neg;
    logic [fpbcs_pkg::SAT_W-1:0]        sat;
    logic [fpbcs_pkg::Q_W-1:0]          q;
    logic signed [fpbcs_pkg::NEXT_W-1:0] next_s, lo_s, hi_s;

    assign lo = r_fm_mode ? fpbcs_pkg::FM_LO : fpbcs_pkg::MFM_LO;
    assign hi = r_fm_mode ? fpbcs_pkg::FM_HI : fpbcs_pkg::MFM_HI;

    assign last = (r_k == fpbcs_pkg::K_W'(fpbcs_pkg::MAX_CELLS))
               || (fpbcs_pkg::CMP_W'({r_interval, 1'b0}) < r_thr);

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_sts.last     = last;

    assign err_i   = fpbcs_pkg::ERR_W'(r_interval);
    assign err_a   = fpbcs_pkg::ERR_W'(r_acc);
    assign err_neg = err_a > err_i;
    assign err_mag = err_neg ? (err_a - err_i) : (err_i - err_a);

    assign sat = (r_prod >= fpbcs_pkg::PROD_W'(2 ** fpbcs_pkg::SAT_W))
               ? {fpbcs_pkg::SAT_W{1'b1}} : r_prod[fpbcs_pkg::SAT_W-1:0];

    assign q      = r_rprod[fpbcs_pkg::DIV_SHIFT +: fpbcs_pkg::Q_W];
    assign lo_s   = $signed({2'b00, lo});
    assign hi_s   = $signed({2'b00, hi});

    always_comb begin
        if (r_neg) begin
            next_s = $signed({2'b00, r_period})
                   - $signed(fpbcs_pkg::NEXT_W'(q));
        end else begin
            next_s = $signed({2'b00, r_period})
                   + $signed(fpbcs_pkg::NEXT_W'(q));
        end
        if (next_s < lo_s) begin
            n_period = lo;
        end else if (next_s > hi_s) begin
            n_period = hi;
        end else begin
            n_period = next_s[fpbcs_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm_mode <= 1'b0;
            r_gain    <= fpbcs_pkg::GAIN_W'(fpbcs_pkg::GAIN_RESET);
            r_period  <= fpbcs_pkg::MFM_NOM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpbcs_pkg::CFG_FM_MODE: begin
                    r_fm_mode <= i_cfg_data[0];
                    r_period  <= i_cfg_data[0] ? fpbcs_pkg::FM_NOM : fpbcs_pkg::MFM_NOM;
                end
                fpbcs_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_data[fpbcs_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_cmd.upd) begin
            r_period <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_interval <= i_interval_ns;
            r_k        <= fpbcs_pkg::K_W'(1);
            r_acc      <= fpbcs_pkg::ACC_W'(r_period);
            r_thr      <= fpbcs_pkg::CMP_W'(r_period)
                        + fpbcs_pkg::CMP_W'({r_period, 1'b0});
            r_first    <= 1'b1;
        end else if (i_cmd.emit && !last) begin
            r_k     <= r_k + fpbcs_pkg::K_W'(1);
            r_acc   <= r_acc + fpbcs_pkg::ACC_W'(r_period);
            r_thr   <= r_thr + fpbcs_pkg::CMP_W'({r_period, 1'b0});
            r_first <= 1'b0;
        end
        if (i_cmd.mul1) begin
            r_neg  <= err_neg;
            r_prod <= fpbcs_pkg::PROD_W'(err_mag) * fpbcs_pkg::PROD_W'(r_gain);
        end
        if (i_cmd.mul2) begin
            r_rprod <= fpbcs_pkg::RPROD_W'(sat)
                     * fpbcs_pkg::RPROD_W'(fpbcs_pkg::RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_bit  <= r_first;
            r_out_last <= last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cell_bit  = r_out_bit;
    assign o_last_cell = r_out_last;

endmodule

### sv/fpbcs_ctrl.sv
module fpbcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fpbcs_pkg::t_dp_sts  i_sts,
    output fpbcs_pkg::t_dp_cmd  o_cmd,
    output logic                o_stall
);

    fpbcs_pkg::t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_stall    = 1'b1;
        case (r_state)
            fpbcs_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = fpbcs_pkg::S_EMIT;
                end
            end
            fpbcs_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.last) begin
                    n_state = fpbcs_pkg::S_MUL1;
                end
            end
            fpbcs_pkg::S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = fpbcs_pkg::S_MUL2;
            end
            fpbcs_pkg::S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = fpbcs_pkg::S_UPD;
            end
            fpbcs_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = fpbcs_pkg::S_IDLE;
            end
            default: begin
                n_state = fpbcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpbcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("cell emitted into a full output register");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == fpbcs_pkg::S_EMIT))
        else $error("accepted transaction did not start emission");

    a_upd_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |-> $past(o_cmd.mul2))
        else $error("period update without reciprocal multiply");

endmodule

### sv/flux_pll_bit_cell_separator.sv
// Flux-interval bit-cell separator. Each accepted transaction carries one
// flux interval in ns; the block returns round(interval / cell period),
// clamped to 1..MAX_CELLS, cells: a 1 cell first, then zeros, the final one
// flagged by o_last_cell. The cell period then moves by gain_percent of the
// timing error and stays within 75%..125% of nominal (2000 ns MFM, 4000 ns
// FM); writing fm_mode reloads it to nominal. An accepted interval is
// emitted cell by cell, then the two-multiplier period update runs through
// the states MUL1, MUL2 and UPD. Cells go out one per cycle through an
// output register while i_stall does not hold it; the input is stalled
// until the update is done.
module flux_pll_bit_cell_separator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [fpbcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fpbcs_pkg::INTERVAL_W-1:0]    i_interval_ns,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_cell_bit,
    output logic                                o_last_cell
);

    fpbcs_pkg::t_dp_cmd cmd;
    fpbcs_pkg::t_dp_sts sts;

    fpbcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    fpbcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_interval_ns (i_interval_ns),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_cell_bit    (o_cell_bit),
        .o_last_cell   (o_last_cell)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic cell_bit;
        logic last_cell;
    } t_cell;

    class t_cell_board;
        bit                  fm;
        int                  gain;
        int                  period;
        int                  errors;
        t_cell               due_cells[$];

        function new();
            fm      = 1'b0;
            gain    = fpbcs_pkg::GAIN_RESET;
            period  = fpbcs_pkg::NOM_MFM;
            errors  = 0;
        endfunction

        function int nominal();
            return fm ? fpbcs_pkg::NOM_FM : fpbcs_pkg::NOM_MFM;
        endfunction

        function void write_reg(logic [0:0] idx, int val);
            if (idx == fpbcs_pkg::CFG_FM_MODE) begin
                fm     = val[0];
                period = nominal();
            end else if (idx == fpbcs_pkg::CFG_GAIN) begin
                gain = val & 127;
            end
        endfunction

        // one accepted interval: queue its cells, then pull the period
        function void split_interval(logic [fpbcs_pkg::INTERVAL_W-1:0] interval);
            int iv, lo, hi, per, count, err, adj, nxt;
            t_cell c;
            iv  = interval;
            lo  = nominal() * fpbcs_pkg::MIN_PCT / 100;
            hi  = nominal() * fpbcs_pkg::MAX_PCT / 100;
            per = period;
            if (per < lo) per = lo;
            if (per > hi) per = hi;
            count = (2 * iv + per) / (2 * per);
            if (count < 1) count = 1;
            if (count > fpbcs_pkg::MAX_CELLS) count = fpbcs_pkg::MAX_CELLS;
            for (int k = 0; k < count; k++) begin
                c.cell_bit  = (k == 0);
                c.last_cell = (k == count - 1);
                due_cells = {due_cells, c};
            end
            err = iv - count * per;
            adj = (err * gain) / 100;
            nxt = per + adj;
            if (nxt < lo) nxt = lo;
            if (nxt > hi) nxt = hi;
            period = nxt & 13'h1FFF;
        endfunction

        function void check_cell(logic cell_bit, logic last_cell);
            t_cell want;
            if (due_cells.size() == 0) begin
                errors++;
                $display("%0t: unexpected cell, expected none, actual bit=%0b last=%0b",
                         $time, cell_bit, last_cell);
                return;
            end
            want = due_cells.pop_front();
            if (want.cell_bit !== cell_bit) begin
                errors++;
                $display("%0t: cell_bit expected %0b actual %0b",
                         $time, want.cell_bit, cell_bit);
            end
            if (want.last_cell !== last_cell) begin
                errors++;
                $display("%0t: last_cell expected %0b actual %0b",
                         $time, want.last_cell, last_cell);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [0:0]                         i_cfg_index;
    logic [fpbcs_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                               i_valid;
    logic                               o_stall;
    logic [fpbcs_pkg::INTERVAL_W-1:0]   i_interval_ns;
    logic                               o_valid;
    logic                               i_stall;
    logic                               o_cell_bit;
    logic                               o_last_cell;

    int                     idle_pct;
    int                     stall_pct;
    t_cell_board            board;

    flux_pll_bit_cell_separator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_interval_ns (i_interval_ns),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cell_bit    (o_cell_bit),
        .o_last_cell   (o_last_cell)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            board.check_cell(o_cell_bit, o_last_cell);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_interval(input logic [fpbcs_pkg::INTERVAL_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_interval_ns <= v;
        do @(posedge i_clk); while (o_stall);
        board.split_interval(v);
    endtask

    // let the cell stream empty and the period update settle
    task automatic drain();
        i_valid <= 1'b0;
        while (board.due_cells.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= fpbcs_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        board.write_reg(idx, val);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [fpbcs_pkg::INTERVAL_W-1:0] jittered_interval();
        int nom, k, j, v;
        nom = board.nominal();
        case ($urandom_range(9))
            0: v = $urandom_range(65535);
            1: v = $urandom_range(nom * 9, 65535);
            2: v = $urandom_range(nom / 2);
            default: begin
                k = ($urandom_range(4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                j = $urandom_range(nom * 90 / 100) - nom * 45 / 100;
                v = k * nom + j;
            end
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return fpbcs_pkg::INTERVAL_W'(v);
    endfunction

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int g;
        board         = new();
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_interval_ns = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // MFM after reset: rounding edges, saturation, bit patterns
        send_interval(16'd0);
        send_interval(16'd1);
        send_interval(16'd999);
        send_interval(16'd1000);
        send_interval(16'd2999);
        send_interval(16'd3000);
        send_interval(16'd4000);
        send_interval(16'd6000);
        send_interval(16'd16999);
        send_interval(16'd17000);
        send_interval(16'hFFFF);
        send_interval(16'h5555);
        send_interval(16'hAAAA);

        write_reg(fpbcs_pkg::CFG_GAIN, 127);
        send_interval(16'd3000);
        send_interval(16'd1500);
        send_interval(16'd7000);
        send_interval(16'd1000);

        write_reg(fpbcs_pkg::CFG_GAIN, 0);
        send_interval(16'd4100);
        send_interval(16'd2050);

        write_reg(fpbcs_pkg::CFG_GAIN, 100);
        write_reg(fpbcs_pkg::CFG_FM_MODE, 1);
        send_interval(16'd4000);
        send_interval(16'd6000);
        send_interval(16'd12000);
        send_interval(16'hFFFF);

        // same-value mode write still reloads the period
        write_reg(fpbcs_pkg::CFG_FM_MODE, 1);
        send_interval(16'd2000);
        write_reg(fpbcs_pkg::CFG_FM_MODE, 0);
        send_interval(16'd2000);

        for (int phase = 0; phase < 4; phase++) begin
            for (int s = 0; s < 2; s++) begin
                case ($urandom_range(3))
                    0: g = 0;
                    1: g = 100;
                    2: g = 127;
                    default: g = $urandom_range(127);
                endcase
                write_reg(fpbcs_pkg::CFG_GAIN, g);
                write_reg(fpbcs_pkg::CFG_FM_MODE, (phase + s) % 2);
                case (phase)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 76; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 76; end
                    default: begin idle_pct = 27; stall_pct = 27; end
                endcase
                for (int n = 0; n < 45; n++)
                    send_interval(jittered_interval());
            end
        end

        drain();
        if (board.due_cells.size() != 0) begin
            board.errors++;
            $display("%0t: %0d cells expected but not received, actual none",
                     $time, board.due_cells.size());
        end
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
